// ----- hw/rtl/mfft_pkg.sv -----
// Package for the Moran family fixation tracker: defaults, FSM state and control bundles.
`timescale 1ns / 1ps

package mfft_pkg;

   localparam int POP_MAX_DEF = 256;
   localparam int MEMBER_W = 8;
   localparam int POP_W = 9;
   localparam int COUNT_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [POP_W-1:0] POP_RESET = 9'd256;
   localparam logic [POP_W-1:0] POP_MIN = 9'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LABEL  = 4'b0010,
      ST_SIZE   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;
      logic label;
      logic size;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full_path;
   } status_type;

endpackage

// ----- hw/rtl/mfft_ctrl.sv -----
// Controller FSM: sequences label read, size update and result handoff.
`timescale 1ns / 1ps

module mfft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mfft_pkg::status_type status,
   output mfft_pkg::cmd_type    cmd
);

   mfft_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != mfft_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept = (state_ff == mfft_pkg::ST_IDLE) && req_valid;
      cmd.label  = (state_ff == mfft_pkg::ST_LABEL);
      cmd.size   = (state_ff == mfft_pkg::ST_SIZE);
      cmd.finish = (state_ff == mfft_pkg::ST_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfft_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.full_path ? mfft_pkg::ST_LABEL : mfft_pkg::ST_FINISH;
            end
         end
         mfft_pkg::ST_LABEL:  state_in = mfft_pkg::ST_SIZE;
         mfft_pkg::ST_SIZE:   state_in = mfft_pkg::ST_FINISH;
         mfft_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = mfft_pkg::ST_IDLE;
            end
         end
         default: state_in = mfft_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfft_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/mfft_datapath.sv -----
// Datapath: family label and size memories, valid bits, counters, CSR and result registers.
`timescale 1ns / 1ps

module mfft_datapath #(
   parameter int POP_MAX = mfft_pkg::POP_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mfft_pkg::cmd_type                     cmd,
   output mfft_pkg::status_type                  status,
   input  logic                                  req_new_run,
   input  logic [mfft_pkg::MEMBER_W-1:0]         req_dying_member,
   input  logic [mfft_pkg::MEMBER_W-1:0]         req_replicating_member,
   output logic [mfft_pkg::COUNT_W-1:0]          rsp_events_counted,
   output logic [mfft_pkg::POP_W-1:0]            rsp_families_remaining,
   output logic                                  rsp_fixed,
   output logic                                  rsp_index_error,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mfft_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mfft_pkg::CSR_DATA_W-1:0]       csr_prdata
);

   localparam int IDX_W = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
   localparam int SZ_W = $clog2(POP_MAX + 1);
   localparam logic [mfft_pkg::POP_W-1:0] PopCap = (POP_MAX > 511) ? 9'd511 : 9'(POP_MAX);
   localparam logic [SZ_W-1:0] SizeCap = SZ_W'(POP_MAX);
   localparam logic [SZ_W-1:0] SizeOne = SZ_W'(1);
   localparam logic [mfft_pkg::COUNT_W-1:0] CountMax = '1;

   function automatic logic [mfft_pkg::POP_W-1:0] clamp_pop(
      input logic [mfft_pkg::POP_W-1:0] p
   );
      logic [mfft_pkg::POP_W-1:0] r;
      r = p;
      if (p < mfft_pkg::POP_MIN) r = mfft_pkg::POP_MIN;
      else if (p > PopCap) r = PopCap;
      return r;
   endfunction

   logic [IDX_W-1:0] fam_mem [POP_MAX];
   logic [SZ_W-1:0]  size_mem [POP_MAX];

   logic [mfft_pkg::POP_W-1:0]   pop_ff, pop_in;
   logic [mfft_pkg::POP_W-1:0]   live_ff, live_in;
   logic [mfft_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic                         fixed_ff, fixed_in;
   logic [POP_MAX-1:0]           mvalid_ff, mvalid_in;
   logic [POP_MAX-1:0]           svalid_ff, svalid_in;

   logic [IDX_W-1:0] d_addr_ff, r_addr_ff;
   logic             err_ff, apply_ff, full_ff;
   logic [IDX_W-1:0] fam_rd0_ff, fam_rd1_ff;
   logic [IDX_W-1:0] df_ff, rf_ff;
   logic [SZ_W-1:0]  size_rd0_ff, size_rd1_ff;
   logic [SZ_W-1:0]  rs_new_ff;

   logic [mfft_pkg::COUNT_W-1:0] out_cnt_ff;
   logic [mfft_pkg::POP_W-1:0]   out_live_ff;
   logic                         out_fixed_ff, out_err_ff;

   logic                         cfg_we, start_run;
   logic [mfft_pkg::POP_W-1:0]   pop_eff;
   logic                         err_now, fixed_eff, apply_now;
   logic [IDX_W-1:0]             d_addr_now, r_addr_now;
   logic [IDX_W-1:0]             df, rf;
   logic [SZ_W-1:0]              ds, rs, ds_dec, rs_base, rs_new, final_df;
   logic                         same_fam, dec_live, fixed_new;
   logic                         size_we;
   logic [IDX_W-1:0]             size_wa;
   logic [SZ_W-1:0]              size_wd;
   logic [mfft_pkg::COUNT_W-1:0] cnt_base;

   assign cfg_we    = csr_psel && csr_penable && csr_pwrite;
   assign start_run = cfg_we || (cmd.accept && req_new_run);
   assign pop_eff   = clamp_pop(pop_ff);
   assign csr_prdata = {{(mfft_pkg::CSR_DATA_W - mfft_pkg::POP_W){1'b0}}, pop_ff};

   assign d_addr_now = IDX_W'(req_dying_member);
   assign r_addr_now = IDX_W'(req_replicating_member);
   assign err_now    = ({1'b0, req_dying_member} >= pop_eff)
                    || ({1'b0, req_replicating_member} >= pop_eff);
   assign fixed_eff  = req_new_run ? 1'b0 : fixed_ff;
   assign apply_now  = !err_now && !fixed_eff;
   assign status.full_path = apply_now && (req_dying_member != req_replicating_member);

   // label lookup
   assign df = mvalid_ff[d_addr_ff] ? fam_rd0_ff : d_addr_ff;
   assign rf = mvalid_ff[r_addr_ff] ? fam_rd1_ff : r_addr_ff;

   // size update
   always_comb begin
      ds       = svalid_ff[df_ff] ? size_rd0_ff : SizeOne;
      rs       = svalid_ff[rf_ff] ? size_rd1_ff : SizeOne;
      same_fam = (df_ff == rf_ff);
      ds_dec   = (ds == '0) ? '0 : ds - SizeOne;
      rs_base  = same_fam ? ds_dec : rs;
      rs_new   = (rs_base < SizeCap) ? rs_base + SizeOne : rs_base;
      final_df = same_fam ? rs_new : ds_dec;
      dec_live = (final_df == '0) && (live_ff != '0);
   end

   always_comb begin
      size_we = 1'b0;
      size_wa = df_ff;
      size_wd = ds_dec;
      if (cmd.size) begin
         size_we = 1'b1;
      end else if (cmd.finish && full_ff) begin
         size_we = 1'b1;
         size_wa = rf_ff;
         size_wd = rs_new_ff;
      end
   end

   assign fixed_new = fixed_ff || (apply_ff && (live_ff == 9'd1));
   assign cnt_base  = req_new_run ? '0 : cnt_ff;

   always_comb begin
      pop_in    = pop_ff;
      live_in   = live_ff;
      cnt_in    = cnt_ff;
      fixed_in  = fixed_ff;
      mvalid_in = mvalid_ff;
      svalid_in = svalid_ff;
      if (cfg_we) begin
         pop_in   = csr_pwdata[mfft_pkg::POP_W-1:0];
         live_in  = clamp_pop(csr_pwdata[mfft_pkg::POP_W-1:0]);
         cnt_in   = '0;
         fixed_in = 1'b0;
      end else if (cmd.accept) begin
         if (req_new_run) begin
            live_in  = pop_eff;
            fixed_in = 1'b0;
         end
         cnt_in = cnt_base;
         if (apply_now && (cnt_base != CountMax)) begin
            cnt_in = cnt_base + 32'd1;
         end
      end else if (cmd.size) begin
         if (dec_live) live_in = live_ff - 9'd1;
         mvalid_in[d_addr_ff] = 1'b1;
         svalid_in[df_ff]     = 1'b1;
      end else if (cmd.finish) begin
         fixed_in = fixed_new;
         if (full_ff) svalid_in[rf_ff] = 1'b1;
      end
      if (start_run) begin
         mvalid_in = '0;
         svalid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff    <= mfft_pkg::POP_RESET;
         live_ff   <= clamp_pop(mfft_pkg::POP_RESET);
         cnt_ff    <= '0;
         fixed_ff  <= 1'b0;
         mvalid_ff <= '0;
         svalid_ff <= '0;
      end else begin
         pop_ff    <= pop_in;
         live_ff   <= live_in;
         cnt_ff    <= cnt_in;
         fixed_ff  <= fixed_in;
         mvalid_ff <= mvalid_in;
         svalid_ff <= svalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         d_addr_ff  <= d_addr_now;
         r_addr_ff  <= r_addr_now;
         err_ff     <= err_now;
         apply_ff   <= apply_now;
         full_ff    <= status.full_path;
         fam_rd0_ff <= fam_mem[d_addr_now];
         fam_rd1_ff <= fam_mem[r_addr_now];
      end
      if (cmd.label) begin
         df_ff       <= df;
         rf_ff       <= rf;
         size_rd0_ff <= size_mem[df];
         size_rd1_ff <= size_mem[rf];
      end
      if (cmd.size) begin
         rs_new_ff          <= rs_new;
         fam_mem[d_addr_ff] <= rf_ff;
      end
      if (size_we) begin
         size_mem[size_wa] <= size_wd;
      end
      if (cmd.finish) begin
         out_cnt_ff   <= cnt_ff;
         out_live_ff  <= live_ff;
         out_fixed_ff <= fixed_new;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_events_counted     = out_cnt_ff;
   assign rsp_families_remaining = out_live_ff;
   assign rsp_fixed              = out_fixed_ff;
   assign rsp_index_error        = out_err_ff;

endmodule

// ----- hw/rtl/moran_family_fixation_tracker.sv -----
// Top level of the Moran family fixation tracker: controller, datapath and CSR port.
`timescale 1ns / 1ps

// Usage:
// - req_ channel: one Moran event per transaction (new_run, dying_member,
//   replicating_member), taken when req_valid is high and req_stall is low.
// - rsp_ channel: one result per event (events_counted, families_remaining,
//   fixed, index_error), taken when rsp_valid is high and rsp_stall is low.
// - csr_ port: population_size at byte address 0; a write also starts a new
//   run. Write only while no event is in flight.
// - An event that changes families goes through label read, size read,
//   size/label write, then result load with the replicating family's size
//   write. The two dependent reads and the single write port of the size
//   memory set these steps. The next event is accepted only after the result load.
// - Erroneous, same-member, and post-fixation events skip the label and size
//   steps and go from acceptance straight to the result load.
// - One event is worked on at a time; req_stall stays high until its result
//   is loaded into the output register.
// - A stalled result holds; the next event may be accepted while it waits,
//   but its result is not loaded until the output register is taken.
// - Reset: population 256, all families fresh, count zero, not fixed.
module moran_family_fixation_tracker #(
   parameter int POP_MAX = mfft_pkg::POP_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_new_run,
   input  logic [mfft_pkg::MEMBER_W-1:0]         req_dying_member,
   input  logic [mfft_pkg::MEMBER_W-1:0]         req_replicating_member,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mfft_pkg::COUNT_W-1:0]          rsp_events_counted,
   output logic [mfft_pkg::POP_W-1:0]            rsp_families_remaining,
   output logic                                  rsp_fixed,
   output logic                                  rsp_index_error,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mfft_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mfft_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mfft_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   mfft_pkg::cmd_type    cmd;
   mfft_pkg::status_type status;
   logic                 csr_sel_reg;

   // single register: every address in the window decodes to population_size
   assign csr_sel_reg = csr_psel && (csr_paddr[mfft_pkg::CSR_ADDR_W-1:0] <= 2'd3);
   assign csr_pready  = 1'b1;

   mfft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mfft_datapath #(
      .POP_MAX (POP_MAX)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_new_run            (req_new_run),
      .req_dying_member       (req_dying_member),
      .req_replicating_member (req_replicating_member),
      .rsp_events_counted     (rsp_events_counted),
      .rsp_families_remaining (rsp_families_remaining),
      .rsp_fixed              (rsp_fixed),
      .rsp_index_error        (rsp_index_error),
      .csr_psel               (csr_sel_reg),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata)
   );

endmodule
